### src/rsmlc_pkg.sv
// Package for the range sensor median/LUT converter.
// Holds table constants, widths, register indexes and shared types. No dependencies.
`timescale 1ns / 1ps
package rsmlc_pkg;
    localparam int SampleW   = 10;
    localparam int DistW     = 11;
    localparam int StatusW   = 2;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 10;
    localparam int StoredPts = 17;
    localparam int DefWindow = 5;
    localparam int DefPoints = 17;

    localparam logic [CfgIdxW-1:0] RegMode  = 2'd0;
    localparam logic [CfgIdxW-1:0] RegDisc  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegFar   = 2'd2;
    localparam logic [CfgIdxW-1:0] RegNear  = 2'd3;

    localparam logic [StatusW-1:0] StOk    = 2'd0;
    localparam logic [StatusW-1:0] StClose = 2'd1;
    localparam logic [StatusW-1:0] StFar   = 2'd2;
    localparam logic [StatusW-1:0] StDisc  = 2'd3;

    function automatic logic [SampleW-1:0] pt_level(input logic [4:0] i);
        case (i)
            5'd0: pt_level = 10'd92;   5'd1: pt_level = 10'd98;
            5'd2: pt_level = 10'd106;  5'd3: pt_level = 10'd115;
            5'd4: pt_level = 10'd123;  5'd5: pt_level = 10'd133;
            5'd6: pt_level = 10'd147;  5'd7: pt_level = 10'd164;
            5'd8: pt_level = 10'd180;  5'd9: pt_level = 10'd205;
            5'd10: pt_level = 10'd235; 5'd11: pt_level = 10'd262;
            5'd12: pt_level = 10'd297; 5'd13: pt_level = 10'd327;
            5'd14: pt_level = 10'd368; 5'd15: pt_level = 10'd440;
            5'd16: pt_level = 10'd512;
            default: pt_level = 10'd0;
        endcase
    endfunction

    function automatic logic [DistW-1:0] pt_dist(input logic [4:0] i);
        case (i)
            5'd0: pt_dist = 11'd1500;  5'd1: pt_dist = 11'd1400;
            5'd2: pt_dist = 11'd1300;  5'd3: pt_dist = 11'd1200;
            5'd4: pt_dist = 11'd1100;  5'd5: pt_dist = 11'd1000;
            5'd6: pt_dist = 11'd900;   5'd7: pt_dist = 11'd800;
            5'd8: pt_dist = 11'd700;   5'd9: pt_dist = 11'd600;
            5'd10: pt_dist = 11'd500;  5'd11: pt_dist = 11'd450;
            5'd12: pt_dist = 11'd400;  5'd13: pt_dist = 11'd350;
            5'd14: pt_dist = 11'd300;  5'd15: pt_dist = 11'd250;
            5'd16: pt_dist = 11'd200;
            default: pt_dist = 11'd0;
        endcase
    endfunction

    // controller -> datapath
    typedef struct packed {
        logic store;      // write sample into ring
        logic init;       // start report: clear scan state
        logic scan;       // one ring element step (median count / sum)
        logic div_start;  // load divider
        logic div_step;   // one quotient bit
        logic fix;        // latch filtered value, classify
        logic seg_step;   // test one table segment
        logic finish;     // final distance from quotient
        logic take;       // output accepted
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;       // ring filled once
        logic scan_done;  // last element scanned
        logic div_done;   // quotient complete
        logic in_range;   // classification passed thresholds
        logic seg_hit;    // current segment contains value
        logic seg_last;   // no more segments
    } t_sts;
endpackage

### src/rsmlc_ctrl.sv
// Controller state machine for the range sensor converter.
// Depends on rsmlc_pkg; drives command struct to rsmlc_dp.
`timescale 1ns / 1ps
module rsmlc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  rsmlc_pkg::t_sts    i_sts,
    output rsmlc_pkg::t_cmd    o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_FIX  = 6'b000100,
        S_SEG  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign w_acc       = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && !i_req_type) begin
                    o_cmd.store = 1'b1;
                end else if (w_acc && i_sts.full) begin
                    o_cmd.init = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_SEG;
            end
            S_SEG: begin
                if (!i_sts.in_range || i_sts.seg_hit || i_sts.seg_last) begin
                    o_cmd.div_start = i_sts.in_range && i_sts.seg_hit;
                    n_state = (i_sts.in_range && i_sts.seg_hit) ? S_FIN : S_OUT;
                end else begin
                    o_cmd.seg_step = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.take = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

### src/rsmlc_dp.sv
// Datapath for the range sensor converter: ring, median/mean, divider, table walk.
// Depends on rsmlc_pkg; commanded by rsmlc_ctrl.
`timescale 1ns / 1ps
module rsmlc_dp #(
    parameter int WINDOW       = rsmlc_pkg::DefWindow,
    parameter int TABLE_POINTS = rsmlc_pkg::DefPoints
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [rsmlc_pkg::SampleW-1:0]     i_sample,
    input  logic                              i_cfg_we,
    input  logic [rsmlc_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [rsmlc_pkg::CfgDataW-1:0]    i_cfg_data,
    input  rsmlc_pkg::t_cmd                   i_cmd,
    output rsmlc_pkg::t_sts                   o_sts,
    output logic [rsmlc_pkg::SampleW-1:0]     o_latest,
    output logic [rsmlc_pkg::SampleW-1:0]     o_filt,
    output logic [rsmlc_pkg::DistW-1:0]       o_dist,
    output logic [rsmlc_pkg::StatusW-1:0]     o_status
);
    localparam int SW    = rsmlc_pkg::SampleW;
    localparam int DW    = rsmlc_pkg::DistW;
    localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int SUMW  = SW + CW;
    localparam int PTS   = (TABLE_POINTS < rsmlc_pkg::StoredPts) ?
                           TABLE_POINTS : rsmlc_pkg::StoredPts;
    localparam int PW    = 5;
    // dividend: product of distance step and offset, up to 21 bits
    localparam int NW    = (SUMW > 2 * SW + 1) ? SUMW : 2 * SW + 1;
    localparam int QCW   = $clog2(NW + 1);
    localparam int MID   = WINDOW / 2;
    // floor mean by reciprocal multiply; RK bits keep the error below one step
    localparam int RK    = SUMW + CW;
    localparam logic [RK-1:0] RECIP = RK'(((1 << RK) + WINDOW - 1) / WINDOW);

    logic [SW-1:0] r_ring [WINDOW];
    logic [IW-1:0] r_wslot, r_lslot;
    logic [CW-1:0] r_fill;
    logic          r_mode;
    logic [SW-1:0] r_disc, r_far, r_near;

    // scan: outer index i over candidates, inner j counts elements
    logic [IW-1:0] r_i, r_j;
    logic [CW-1:0] r_lt, r_le;
    logic [SUMW-1:0] r_sum;
    logic [SW-1:0]   r_med;
    logic            r_med_ok;

    logic [NW-1:0]  r_rem, r_quo;
    logic [SW:0]    r_div;
    logic [QCW-1:0] r_qc;

    logic [SW-1:0] r_filt;
    logic [PW-1:0] r_seg;
    logic          r_inr;
    logic [DW-1:0] r_dist;
    logic [rsmlc_pkg::StatusW-1:0] r_stat;
    logic          r_desc;

    // ring write and config
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_ring[r_wslot] <= i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_lslot <= '0;
            r_fill  <= '0;
            r_mode  <= 1'b0;
            r_disc  <= SW'(30);
            r_far   <= SW'(92);
            r_near  <= SW'(512);
        end else begin
            if (i_cmd.store) begin
                r_lslot <= r_wslot;
                r_wslot <= (r_wslot == IW'(WINDOW - 1)) ? '0 : r_wslot + 1'b1;
                if (r_fill != CW'(WINDOW)) r_fill <= r_fill + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rsmlc_pkg::RegMode: r_mode <= i_cfg_data[0];
                    rsmlc_pkg::RegDisc: r_disc <= i_cfg_data;
                    rsmlc_pkg::RegFar:  r_far  <= i_cfg_data;
                    rsmlc_pkg::RegNear: r_near <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // median by rank: candidate ring[i] is the median if count(<) <= MID < count(<=)
    logic [SW-1:0] w_ci, w_cj;
    logic [CW-1:0] w_lt, w_le;
    logic          w_jlast, w_ilast;
    assign w_ci    = r_ring[r_i];
    assign w_cj    = r_ring[r_j];
    assign w_jlast = (r_j == IW'(WINDOW - 1));
    assign w_ilast = (r_i == IW'(WINDOW - 1));
    assign w_lt    = r_lt + CW'(w_cj < w_ci);
    assign w_le    = r_le + CW'(w_cj <= w_ci);

    logic [SUMW+RK-1:0] w_prod;
    logic [SW-1:0]      w_mean;
    assign w_prod = {{RK{1'b0}}, r_sum} * {{SUMW{1'b0}}, RECIP};
    assign w_mean = w_prod[RK +: SW];

    // segment walk
    logic [SW-1:0] w_a0, w_a1;
    logic [DW-1:0] w_d0, w_d1;
    logic          w_hit;
    assign w_a0  = rsmlc_pkg::pt_level(r_seg);
    assign w_a1  = rsmlc_pkg::pt_level(r_seg + 1'b1);
    assign w_d0  = rsmlc_pkg::pt_dist(r_seg);
    assign w_d1  = rsmlc_pkg::pt_dist(r_seg + 1'b1);
    assign w_hit = (r_filt >= w_a0) && (r_filt <= w_a1);

    // restoring divider step
    logic [NW:0]   w_trial;
    logic [NW-1:0] w_qnext;
    assign w_trial = {r_rem, r_quo[NW-1]} - {{(NW - SW){1'b0}}, r_div};
    assign w_qnext = {r_quo[NW-2:0], !w_trial[NW]};

    logic [SW-1:0] w_span, w_off;
    logic [DW-1:0] w_step;
    assign w_span = w_a1 - w_a0;
    assign w_off  = r_filt - w_a0;
    assign w_step = (w_d0 >= w_d1) ? (w_d0 - w_d1) : (w_d1 - w_d0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_i <= '0; r_j <= '0; r_lt <= '0; r_le <= '0;
            r_sum <= '0; r_med_ok <= 1'b0;
        end else if (i_cmd.scan) begin
            if (r_i == '0) r_sum <= r_sum + SUMW'(w_cj);
            if (w_jlast) begin
                if (!r_med_ok && w_lt <= CW'(MID) && w_le > CW'(MID)) begin
                    r_med    <= w_ci;
                    r_med_ok <= 1'b1;
                end
                r_j <= '0; r_lt <= '0; r_le <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1; r_lt <= w_lt; r_le <= w_le;
            end
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_qc   <= '0;
            r_quo  <= NW'(w_step) * NW'(w_off);
            r_div  <= {1'b0, w_span};
            r_desc <= (w_d0 >= w_d1);
            r_dist <= w_d0;
        end else if (i_cmd.div_step) begin
            r_qc  <= r_qc + 1'b1;
            if (!w_trial[NW]) r_rem <= w_trial[NW-1:0];
            else              r_rem <= {r_rem[NW-2:0], r_quo[NW-1]};
            r_quo <= w_qnext;
        end
        if (i_cmd.fix) begin
            r_filt <= r_mode ? w_mean : r_med;
            r_seg  <= '0;
        end else if (i_cmd.seg_step) begin
            r_seg <= r_seg + 1'b1;
        end
        // finish lands with the last divider step: take the completed quotient
        if (i_cmd.finish) begin
            if (r_div == '0)  r_dist <= r_dist;
            else if (r_desc)  r_dist <= r_dist - w_qnext[DW-1:0];
            else              r_dist <= r_dist + w_qnext[DW-1:0];
        end
    end

    // classification, registered at fix
    logic [SW-1:0] w_fv;
    assign w_fv = r_mode ? w_mean : r_med;
    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_inr <= 1'b0;
            if (w_fv < r_disc)      r_stat <= rsmlc_pkg::StDisc;
            else if (w_fv < r_far)  r_stat <= rsmlc_pkg::StFar;
            else if (w_fv > r_near) r_stat <= rsmlc_pkg::StClose;
            else begin
                r_stat <= rsmlc_pkg::StFar;
                r_inr  <= 1'b1;
            end
        end else if (i_cmd.seg_step == 1'b0 && r_inr && w_hit && !i_cmd.finish
                     && i_cmd.div_start) begin
            r_stat <= rsmlc_pkg::StOk;
        end
    end

    assign o_sts.full      = (r_fill == CW'(WINDOW));
    assign o_sts.scan_done = w_ilast && w_jlast;
    assign o_sts.div_done  = (r_qc == QCW'(NW - 1)) && i_cmd.div_step;
    assign o_sts.in_range  = r_inr;
    assign o_sts.seg_hit   = w_hit && (PTS > 1);
    assign o_sts.seg_last  = (r_seg >= PW'(PTS - 2)) || (PTS < 2);

    assign o_latest = r_ring[r_lslot];
    assign o_filt   = r_filt;
    assign o_dist   = (r_stat == rsmlc_pkg::StOk) ? r_dist : '0;
    assign o_status = r_stat;
endmodule

### src/range_sensor_median_lut_converter_top.sv
// Top level of the range sensor median/LUT converter.
// Depends on rsmlc_pkg, rsmlc_ctrl and rsmlc_dp.
`timescale 1ns / 1ps
// Stream of request beats in, report beats out. A store request (tuser 0)
// writes tdata into a ring of WINDOW samples and is taken with no output
// beat. A report request (tuser 1) yields no beat until WINDOW samples have
// been stored since reset; after that it ranks every ring entry against every
// other (also summing for the mean), forms the floor mean by a reciprocal
// multiply in the classify state, checks the thresholds and, when they pass,
// walks the table one segment a cycle and, on a hit, runs a one-bit-per-cycle
// restoring divider for the interpolation. One request is in work at a time;
// tready is low until the report beat has been taken. Configuration writes
// are taken at any edge with i_cfg_we high and must be made while idle.
module range_sensor_median_lut_converter_top #(
    parameter int WINDOW       = rsmlc_pkg::DefWindow,
    parameter int TABLE_POINTS = rsmlc_pkg::DefPoints
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] sample, rest zero
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [9:0] latest_raw, [19:10] filtered_value,
                                        // [30:20] distance_tenths_cm, [32:31] range_status
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);
    rsmlc_pkg::t_cmd w_cmd;
    rsmlc_pkg::t_sts w_sts;
    logic [9:0]  w_latest, w_filt;
    logic [10:0] w_dist;
    logic [1:0]  w_stat;

    rsmlc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rsmlc_dp #(.WINDOW(WINDOW), .TABLE_POINTS(TABLE_POINTS)) u_dp (
        .i_clk, .i_rst_n,
        .i_sample  (s_axis_tdata[9:0]),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_latest  (w_latest),
        .o_filt    (w_filt),
        .o_dist    (w_dist),
        .o_status  (w_stat)
    );

    assign m_axis_tdata = {7'd0, w_stat, w_dist, w_filt, w_latest};
endmodule

### tb/sv/tb.sv
// Testbench for range_sensor_median_lut_converter_top: directed and random request
// beats, with an in-bench predictor of the ring filter and distance table.
// Depends on rsmlc_pkg and the top level only.
`timescale 1ns / 1ps
module tb;
    localparam int RingN = 5;
    localparam int CycleLimit = 2000000;

    typedef struct packed {
        logic [rsmlc_pkg::DistW-1:0]   distance;
        logic [rsmlc_pkg::StatusW-1:0] status;
        logic [rsmlc_pkg::SampleW-1:0] filt;
        logic [rsmlc_pkg::SampleW-1:0] raw;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [9:0]  i_cfg_data = '0;

    range_sensor_median_lut_converter_top u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: a private copy of the ring and the registers.
    logic [rsmlc_pkg::SampleW-1:0] ring [RingN];
    int unsigned        wr_slot, last_slot, stored;
    logic               mode_mean;
    logic [rsmlc_pkg::SampleW-1:0] lvl_disc, lvl_far, lvl_near;

    t_report pending_reports[$];
    int      n_errors;
    int      cycles;
    int      hold_off;     // long receiver stall, counted down in the sink process

    function automatic logic [rsmlc_pkg::SampleW-1:0] ring_filter();
        logic [rsmlc_pkg::SampleW-1:0] s [RingN];
        logic [rsmlc_pkg::SampleW-1:0] t;
        int unsigned sum;
        sum = 0;
        for (int i = 0; i < RingN; i++) begin
            s[i] = ring[i];
            sum += ring[i];
        end
        if (mode_mean) return rsmlc_pkg::SampleW'(sum / RingN);
        for (int i = 0; i < RingN; i++)
            for (int j = 0; j < RingN - 1 - i; j++)
                if (s[j] > s[j+1]) begin
                    t = s[j]; s[j] = s[j+1]; s[j+1] = t;
                end
        return s[RingN/2];
    endfunction

    // Status and interpolated distance for one filtered value.
    function automatic t_report grade(logic [rsmlc_pkg::SampleW-1:0] v);
        int lv [17] = '{92, 98, 106, 115, 123, 133, 147, 164, 180, 205, 235, 262,
                        297, 327, 368, 440, 512};
        int dv [17] = '{1500, 1400, 1300, 1200, 1100, 1000, 900, 800, 700, 600, 500,
                        450, 400, 350, 300, 250, 200};
        t_report r;
        r = '0;
        r.filt = v;
        if (v < lvl_disc) begin r.status = rsmlc_pkg::StDisc; return r; end
        if (v < lvl_far) begin r.status = rsmlc_pkg::StFar; return r; end
        if (v > lvl_near) begin r.status = rsmlc_pkg::StClose; return r; end
        for (int i = 0; i < 16; i++)
            if (v >= lv[i] && v <= lv[i+1]) begin
                // table distances fall, so interpolate downward; lower segment wins ties
                r.distance = rsmlc_pkg::DistW'(dv[i] - ((dv[i] - dv[i+1]) * (v - lv[i]))
                                               / (lv[i+1] - lv[i]));
                r.status = rsmlc_pkg::StOk;
                return r;
            end
        r.status = rsmlc_pkg::StFar;
        return r;
    endfunction

    // Drive one request beat and hold it until taken; update the predictor.
    task automatic send_beat(bit report, logic [rsmlc_pkg::SampleW-1:0] smp);
        t_report r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= report;
        s_axis_tdata  <= {6'd0, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        if (!report) begin
            ring[wr_slot] = smp;
            last_slot = wr_slot;
            wr_slot = (wr_slot + 1) % RingN;
            if (stored < RingN) stored++;
        end else if (stored == RingN) begin
            r = grade(ring_filter());
            r.raw = ring[last_slot];
            pending_reports.push_back(r);
        end
        @(negedge i_clk);
        // random gaps: mostly none or short, a few long; with no gap hold tvalid high
        if ($urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 120)
                                              : $urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rsmlc_pkg::RegMode: mode_mean = val[0];
            rsmlc_pkg::RegDisc: lvl_disc = val;
            rsmlc_pkg::RegFar:  lvl_far = val;
            rsmlc_pkg::RegNear: lvl_near = val;
        endcase
    endtask

    // Sample hovering near the table, with full-range noise now and then.
    function automatic logic [rsmlc_pkg::SampleW-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return rsmlc_pkg::SampleW'($urandom_range(0, 1023));
            1: return rsmlc_pkg::SampleW'($urandom_range(0, 40));
            default: return rsmlc_pkg::SampleW'($urandom_range(80, 560));
        endcase
    endfunction

    task automatic test_directed();
        // report on an empty ring must yield nothing
        send_beat(1'b1, 10'd0);
        send_beat(1'b0, 10'd0);
        send_beat(1'b0, 10'd1023);
        send_beat(1'b1, 10'd0);
        send_beat(1'b0, 10'h155);
        send_beat(1'b0, 10'h2AA);
        send_beat(1'b0, 10'd92);
        send_beat(1'b1, 10'h3FF);
        // segment ends and exact table points
        for (int k = 0; k < 5; k++) send_beat(1'b0, 10'd512);
        send_beat(1'b1, 10'd0);
        for (int k = 0; k < 5; k++) send_beat(1'b0, 10'd98);
        send_beat(1'b1, 10'd0);
        for (int k = 0; k < 5; k++) send_beat(1'b0, 10'd513);
        send_beat(1'b1, 10'd0);
        drain();
    endtask

    task automatic test_random(int n, bit long_stall);
        for (int k = 0; k < n; k++) begin
            if (long_stall && k == n / 2) hold_off = 400;
            if ($urandom_range(0, 2) == 0) send_beat(1'b1, rsmlc_pkg::SampleW'($urandom));
            else send_beat(1'b0, pick_sample());
        end
        drain();
    endtask

    task automatic test_registers();
        // extremes: thresholds pulled off the table ends reach the no-segment case
        write_reg(rsmlc_pkg::RegMode, 10'd1);
        write_reg(rsmlc_pkg::RegDisc, 10'd0);
        write_reg(rsmlc_pkg::RegFar, 10'd0);
        write_reg(rsmlc_pkg::RegNear, 10'd1023);
        test_random(400, 1'b0);
        write_reg(rsmlc_pkg::RegMode, 10'd0);
        write_reg(rsmlc_pkg::RegDisc, 10'd1023);
        write_reg(rsmlc_pkg::RegFar, 10'd1023);
        write_reg(rsmlc_pkg::RegNear, 10'd0);
        test_random(150, 1'b0);
        write_reg(rsmlc_pkg::RegDisc, 10'd200);
        write_reg(rsmlc_pkg::RegFar, 10'd100);
        write_reg(rsmlc_pkg::RegNear, 10'd300);
        test_random(300, 1'b0);
        write_reg(rsmlc_pkg::RegMode, 10'd1);
        write_reg(rsmlc_pkg::RegDisc, 10'd30);
        write_reg(rsmlc_pkg::RegFar, 10'd92);
        write_reg(rsmlc_pkg::RegNear, 10'd512);
        test_random(400, 1'b1);
    endtask

    // Result checker and receiver back-pressure.
    always @(posedge i_clk) begin
        t_report got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{distance: m_axis_tdata[30:20], status: m_axis_tdata[32:31],
                    filt: m_axis_tdata[19:10], raw: m_axis_tdata[9:0]};
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report beat %h", $time, m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_reports.pop_front();
                if (got.raw != want.raw) begin
                    $display("%0t: latest_raw exp %0d got %0d", $time, want.raw, got.raw);
                    n_errors++;
                end
                if (got.filt != want.filt) begin
                    $display("%0t: filtered exp %0d got %0d", $time, want.filt, got.filt);
                    n_errors++;
                end
                if (got.distance != want.distance) begin
                    $display("%0t: distance exp %0d got %0d", $time, want.distance,
                             got.distance);
                    n_errors++;
                end
                if (got.status != want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    n_errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 1) == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 40) == 0) hold_off = $urandom_range(10, 60);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        n_errors = 0;
        cycles = 0;
        hold_off = 0;
        wr_slot = 0; last_slot = 0; stored = 0;
        mode_mean = 1'b0;
        lvl_disc = 10'd30; lvl_far = 10'd92; lvl_near = 10'd512;
        foreach (ring[k]) ring[k] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(700, 1'b1);
        test_registers();
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
